### design/rms_pkg.sv
// ----------------------------------------------------------------------------
// Rate-monotonic scheduler package
// Shared widths, codes, cell command and chain link types.
// ----------------------------------------------------------------------------
`default_nettype none

package rms_pkg;

	localparam int MAX_TASKS_DEF = 16;
	localparam int ID_W          = 22;
	localparam int PER_W         = 16;
	localparam int LOAD_W        = 10;
	localparam int TIME_W        = 32;
	localparam int DVD_W         = 26;
	localparam int APB_AW        = 2;
	localparam int APB_DW        = 32;

	localparam logic [LOAD_W-1:0] LOAD_MAX    = 10'd1023;
	localparam logic [LOAD_W-1:0] LIMIT_RESET = 10'd693;
	localparam logic [9:0]        PER_MILLE   = 10'd1000;

	typedef enum logic [1:0] {
		CMD_REG   = 2'd0,
		CMD_YIELD = 2'd1,
		CMD_DEREG = 2'd2,
		CMD_TICK  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_REJECTED = 2'd1,
		STS_NOTFOUND = 2'd2,
		STS_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_READY = 2'd0,
		ST_SLEEP = 2'd1,
		ST_RUN   = 2'd2,
		ST_NEW   = 2'd3
	} run_state_t;

	typedef enum logic [2:0] {
		CO_NONE,
		CO_REG,
		CO_YIELD,
		CO_DEREG,
		CO_TICK,
		CO_RUN,
		CO_READY
	} cell_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_P1,
		S_ACT,
		S_P2,
		S_DISP_OLD,
		S_DISP_NEW,
		S_RESP
	} fsm_t;

	typedef struct packed {
		cell_op_t            op;
		logic [ID_W-1:0]     id;
		logic [PER_W-1:0]    per;
		logic [LOAD_W-1:0]   load;
		logic [TIME_W-1:0]   now;
	} cell_cmd_t;

	typedef struct packed {
		logic              find_free;
		logic [ID_W-1:0]   key;
	} scan_ctl_t;

	typedef struct packed {
		logic              tok;
		logic              hit;
		logic              best;
		logic [PER_W-1:0]  best_per;
		logic [ID_W-1:0]   best_id;
		logic              cur;
		logic [PER_W-1:0]  cur_per;
		logic [ID_W-1:0]   cur_id;
		logic [LOAD_W-1:0] sum;
	} link_t;

	function automatic logic [LOAD_W-1:0] sat_add(input logic [LOAD_W-1:0] a,
			input logic [LOAD_W-1:0] b);
		logic [LOAD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[LOAD_W] ? LOAD_MAX : s[LOAD_W-1:0];
	endfunction

endpackage

`default_nettype wire

### design/rms_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Produces one quotient bit per cycle for the per-mille load.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [rms_pkg::DVD_W-1:0]  dividend,
	input  wire logic [rms_pkg::PER_W-1:0]  divisor,
	output logic                            done,
	output logic [rms_pkg::DVD_W-1:0]       quotient
);
	import rms_pkg::*;

	localparam int CW = $clog2(DVD_W + 1);

	logic [PER_W-1:0] rem_q;
	logic [PER_W-1:0] dsr_q;
	logic [DVD_W-1:0] dvd_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [PER_W:0]   trial;
	logic [PER_W:0]   diff;

	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		diff  = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			dvd_q <= dividend;
		end else if (busy_q) begin
			if (!diff[PER_W]) begin
				rem_q <= diff[PER_W-1:0];
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[PER_W-1:0];
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign done     = !busy_q && !start;
	assign quotient = dvd_q;

endmodule

`default_nettype wire

### design/rms_cell.sv
// ----------------------------------------------------------------------------
// Task slot cell
// Holds one task slot and folds it into the scan link passed down the row.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_cell #(
	parameter int IW  = 4,
	parameter int IDX = 0
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rms_pkg::cell_cmd_t   cmd_i,
	input  wire logic [IW-1:0]        sel_i,
	input  wire rms_pkg::scan_ctl_t   ctl_i,
	input  wire rms_pkg::link_t       lnk_i,
	input  wire logic [IW-1:0]        hit_idx_i,
	input  wire logic [IW-1:0]        best_idx_i,
	input  wire logic [IW-1:0]        cur_idx_i,
	output rms_pkg::link_t            lnk_o,
	output logic [IW-1:0]             hit_idx_o,
	output logic [IW-1:0]             best_idx_o,
	output logic [IW-1:0]             cur_idx_o
);
	import rms_pkg::*;

	logic              valid_q;
	logic [ID_W-1:0]   id_q;
	logic [PER_W-1:0]  per_q;
	logic [LOAD_W-1:0] load_q;
	run_state_t        state_q;
	logic [TIME_W-1:0] rel_q;

	link_t             nxt;
	logic [IW-1:0]     hit_idx_n;
	logic [IW-1:0]     best_idx_n;
	logic [IW-1:0]     cur_idx_n;
	logic              mine;
	logic              first;
	logic [TIME_W-1:0] rel_n;
	logic [TIME_W-1:0] age;

	always_comb begin
		nxt        = lnk_i;
		hit_idx_n  = hit_idx_i;
		best_idx_n = best_idx_i;
		cur_idx_n  = cur_idx_i;
		if (!lnk_i.hit && (ctl_i.find_free ? !valid_q : (valid_q && id_q == ctl_i.key))) begin
			nxt.hit   = 1'b1;
			hit_idx_n = IW'(IDX);
		end
		if (valid_q && (state_q == ST_READY || state_q == ST_RUN)
				&& (!lnk_i.best || per_q < lnk_i.best_per)) begin
			nxt.best     = 1'b1;
			nxt.best_per = per_q;
			nxt.best_id  = id_q;
			best_idx_n   = IW'(IDX);
		end
		if (valid_q && state_q == ST_RUN) begin
			nxt.cur     = 1'b1;
			nxt.cur_per = per_q;
			nxt.cur_id  = id_q;
			cur_idx_n   = IW'(IDX);
		end
		if (valid_q) begin
			nxt.sum = sat_add(lnk_i.sum, load_q);
		end
	end

	always_comb begin
		mine  = sel_i == IW'(IDX);
		first = state_q == ST_NEW;
		rel_n = (first ? cmd_i.now : rel_q) + TIME_W'(per_q);
		age   = cmd_i.now - rel_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lnk_o      <= '0;
			hit_idx_o  <= '0;
			best_idx_o <= '0;
			cur_idx_o  <= '0;
			valid_q    <= 1'b0;
		end else begin
			lnk_o      <= nxt;
			hit_idx_o  <= hit_idx_n;
			best_idx_o <= best_idx_n;
			cur_idx_o  <= cur_idx_n;
			if (mine && cmd_i.op == CO_REG) begin
				valid_q <= 1'b1;
			end else if (mine && cmd_i.op == CO_DEREG) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd_i.op)
			CO_REG: begin
				if (mine) begin
					id_q    <= cmd_i.id;
					per_q   <= cmd_i.per;
					load_q  <= cmd_i.load;
					state_q <= ST_NEW;
					rel_q   <= '0;
				end
			end
			CO_YIELD: begin
				if (mine) begin
					rel_q <= rel_n;
					if (rel_n >= cmd_i.now) begin
						state_q <= ST_SLEEP;
					end else if (first) begin
						state_q <= ST_READY;
					end
				end
			end
			CO_TICK: begin
				if (valid_q && state_q == ST_SLEEP && !age[TIME_W-1]) begin
					state_q <= ST_READY;
				end
			end
			CO_RUN: begin
				if (mine) begin
					state_q <= ST_RUN;
				end
			end
			CO_READY: begin
				if (mine) begin
					state_q <= ST_READY;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

### design/rate_monotonic_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Rate-monotonic task scheduler
// Task slots sit in a row of cells; a scan token runs down the row to find
// slots, sum the load and pick the shortest-period eligible task.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Beat
// in        input      in_valid/in_ready    cmd, task_id, period_ms, compute_ms
// out       output     out_valid/out_ready  status, running_valid, running_id,
//                                           switched, load_total
// apb       input      psel/penable/pready  admission_limit write or read
//
// An item's time is set by two scans of the cell row and, for a register
// command, the bit-serial load divider.
// Only one item is in work; the next is accepted while a result waits.
// Reset clears every slot's valid bit, the load sum and time, and sets the
// limit to its default.
// A stalled output holds the pipeline before its result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rate_monotonic_task_scheduler_unit #(
	parameter int MAX_TASKS = rms_pkg::MAX_TASKS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  cmd,
	input  wire logic [rms_pkg::ID_W-1:0]    task_id,
	input  wire logic [rms_pkg::PER_W-1:0]   period_ms,
	input  wire logic [rms_pkg::PER_W-1:0]   compute_ms,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [1:0]                       status,
	output logic                             running_valid,
	output logic [rms_pkg::ID_W-1:0]         running_id,
	output logic                             switched,
	output logic [rms_pkg::LOAD_W-1:0]       load_total,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rms_pkg::APB_AW-1:0]  paddr,
	input  wire logic [rms_pkg::APB_DW-1:0]  pwdata,
	output logic [rms_pkg::APB_DW-1:0]       prdata,
	output logic                             pready
);
	import rms_pkg::*;

	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

	fsm_t              state_q, state_n;
	cmd_t              cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [PER_W-1:0]  per_q;
	logic [PER_W-1:0]  cmp_q;
	logic [LOAD_W-1:0] limit_q;
	logic [LOAD_W-1:0] sum_q;
	logic [TIME_W-1:0] now_q;
	logic              go_q;
	status_t           sts_q;

	logic              hit_q;
	logic [IW-1:0]     hit_idx_q;
	logic              bcur_q;
	logic [IW-1:0]     bcur_idx_q;
	logic              best_q;
	logic [IW-1:0]     best_idx_q;
	logic [PER_W-1:0]  best_per_q;
	logic [ID_W-1:0]   best_id_q;
	logic              acur_q;
	logic [IW-1:0]     acur_idx_q;
	logic [PER_W-1:0]  acur_per_q;
	logic [ID_W-1:0]   acur_id_q;
	logic [LOAD_W-1:0] psum_q;

	logic              div_start;
	logic              div_done;
	logic [DVD_W-1:0]  div_q;
	logic [DVD_W-1:0]  dividend;
	logic [LOAD_W-1:0] ld;

	cell_cmd_t         ccmd;
	logic [IW-1:0]     csel;
	scan_ctl_t         ctl;
	logic              take;
	logic              after_v;
	logic [IW-1:0]     after_idx;
	logic              sw;

	link_t             lnk   [MAX_TASKS+1];
	logic [IW-1:0]     h_idx [MAX_TASKS+1];
	logic [IW-1:0]     b_idx [MAX_TASKS+1];
	logic [IW-1:0]     c_idx [MAX_TASKS+1];

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = APB_DW'(limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite) begin
			limit_q <= pwdata[LOAD_W-1:0];
		end
	end

	// Load of a new task; the divider starts on the accepted beat itself.
	assign dividend  = DVD_W'(PER_MILLE) * DVD_W'(compute_ms);
	assign div_start = state_q == S_IDLE && in_valid && cmd_t'(cmd) == CMD_REG;

	rms_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (period_ms),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		if (per_q == '0 || div_q > DVD_W'(LOAD_MAX)) begin
			ld = LOAD_MAX;
		end else begin
			ld = div_q[LOAD_W-1:0];
		end
	end

	// Cell row.
	assign ctl.find_free = cmd_q == CMD_REG;
	assign ctl.key       = id_q;

	always_comb begin
		lnk[0]      = '0;
		lnk[0].tok  = go_q;
		h_idx[0]    = '0;
		b_idx[0]    = '0;
		c_idx[0]    = '0;
	end

	for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
		rms_cell #(
			.IW  (IW),
			.IDX (g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd_i      (ccmd),
			.sel_i      (csel),
			.ctl_i      (ctl),
			.lnk_i      (lnk[g]),
			.hit_idx_i  (h_idx[g]),
			.best_idx_i (b_idx[g]),
			.cur_idx_i  (c_idx[g]),
			.lnk_o      (lnk[g+1]),
			.hit_idx_o  (h_idx[g+1]),
			.best_idx_o (b_idx[g+1]),
			.cur_idx_o  (c_idx[g+1])
		);
	end

	// Dispatch decision from the second scan, set against the first scan's running task.
	always_comb begin
		take      = best_q && (!acur_q || acur_per_q > best_per_q);
		after_v   = take || acur_q;
		after_idx = take ? best_idx_q : acur_idx_q;
		sw        = (bcur_q != after_v) || (bcur_q && after_v && bcur_idx_q != after_idx);
	end

	// Sequencer.
	always_comb begin
		state_n   = state_q;
		ccmd      = '0;
		ccmd.op   = CO_NONE;
		ccmd.id   = id_q;
		ccmd.per  = per_q;
		ccmd.load = ld;
		ccmd.now  = now_q;
		csel      = hit_idx_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_n = (cmd_t'(cmd) == CMD_REG) ? S_DIV : S_P1;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_n = S_P1;
				end
			end
			S_P1: begin
				if (lnk[MAX_TASKS].tok) begin
					state_n = S_ACT;
				end
			end
			S_ACT: begin
				state_n = S_P2;
				case (cmd_q)
					CMD_REG: begin
						if (sat_add(sum_q, ld) <= limit_q && hit_q) begin
							ccmd.op = CO_REG;
						end
					end
					CMD_YIELD: begin
						if (hit_q) begin
							ccmd.op = CO_YIELD;
						end
					end
					CMD_DEREG: begin
						if (hit_q) begin
							ccmd.op = CO_DEREG;
						end
					end
					default: begin
						ccmd.op  = CO_TICK;
						ccmd.now = now_q + 1'b1;
					end
				endcase
			end
			S_P2: begin
				if (lnk[MAX_TASKS].tok) begin
					state_n = S_DISP_OLD;
				end
			end
			S_DISP_OLD: begin
				state_n = S_DISP_NEW;
				csel    = acur_idx_q;
				if (take && acur_q) begin
					ccmd.op = CO_READY;
				end
			end
			S_DISP_NEW: begin
				state_n = S_RESP;
				csel    = best_idx_q;
				if (take) begin
					ccmd.op = CO_RUN;
				end
			end
			S_RESP: begin
				if (!out_valid || out_ready) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	assign in_ready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			go_q      <= 1'b0;
			sum_q     <= '0;
			now_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_n;
			go_q    <= (state_n == S_P1 && state_q != S_P1)
				|| (state_n == S_P2 && state_q != S_P2);
			if (state_q == S_ACT && cmd_q == CMD_TICK) begin
				now_q <= now_q + 1'b1;
			end
			if (state_q == S_P2 && lnk[MAX_TASKS].tok) begin
				sum_q <= lnk[MAX_TASKS].sum;
			end
			if (state_q == S_RESP && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			cmd_q <= cmd_t'(cmd);
			id_q  <= task_id;
			per_q <= period_ms;
			cmp_q <= compute_ms;
		end
		if (state_q == S_P1 && lnk[MAX_TASKS].tok) begin
			hit_q      <= lnk[MAX_TASKS].hit;
			hit_idx_q  <= h_idx[MAX_TASKS];
			bcur_q     <= lnk[MAX_TASKS].cur;
			bcur_idx_q <= c_idx[MAX_TASKS];
		end
		if (state_q == S_ACT) begin
			sts_q <= STS_OK;
			case (cmd_q)
				CMD_REG: begin
					if (sat_add(sum_q, ld) > limit_q) begin
						sts_q <= STS_REJECTED;
					end else if (!hit_q) begin
						sts_q <= STS_FULL;
					end
				end
				CMD_YIELD, CMD_DEREG: begin
					if (!hit_q) begin
						sts_q <= STS_NOTFOUND;
					end
				end
				default: begin
				end
			endcase
		end
		if (state_q == S_P2 && lnk[MAX_TASKS].tok) begin
			best_q     <= lnk[MAX_TASKS].best;
			best_idx_q <= b_idx[MAX_TASKS];
			best_per_q <= lnk[MAX_TASKS].best_per;
			best_id_q  <= lnk[MAX_TASKS].best_id;
			acur_q     <= lnk[MAX_TASKS].cur;
			acur_idx_q <= c_idx[MAX_TASKS];
			acur_per_q <= lnk[MAX_TASKS].cur_per;
			acur_id_q  <= lnk[MAX_TASKS].cur_id;
			psum_q     <= lnk[MAX_TASKS].sum;
		end
		if (state_q == S_RESP && (!out_valid || out_ready)) begin
			status        <= sts_q;
			running_valid <= after_v;
			running_id    <= !after_v ? '0 : (take ? best_id_q : acur_id_q);
			switched      <= sw;
			load_total    <= psum_q;
		end
	end

endmodule

`default_nettype wire

### design/rms_checker.sv
// ----------------------------------------------------------------------------
// Scheduler port checker
// Checks the scheduler's port behavior over time.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic                       in_ready,
	input  wire logic                       out_valid,
	input  wire logic                       out_ready,
	input  wire logic                       running_valid,
	input  wire logic [rms_pkg::ID_W-1:0]   running_id,
	input  wire logic [rms_pkg::LOAD_W-1:0] load_total
);
	import rms_pkg::*;

	a_idle_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !running_valid |-> running_id == '0)
		else $error("running_id set with no running task");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a beat is in work");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without work");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(load_total))
		else $error("stalled result changed");

endmodule

bind rate_monotonic_task_scheduler_unit rms_checker u_rms_checker (.*);

`default_nettype wire
